@@ hdl/periodic_timer_queue_defines.svh @@
// Assertion macros for the periodic timer queue; they sample on clk_i and idle during rst_ni low.
`ifndef PERIODIC_TIMER_QUEUE_DEFINES_SVH
`define PERIODIC_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define PTQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTQ_ASSERT_SAME(lbl, ante, cons, msg)
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/ptq_pkg.sv @@
// Shared types and constants of the periodic timer queue.
package ptq_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned TIME_W        = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned SLOT_FIELD_W  = 4;
  localparam int unsigned S_TDATA_W     = 200;
  localparam int unsigned S_TUSER_W     = 2;
  localparam int unsigned M_TDATA_W     = 136;
  localparam int unsigned M_TUSER_W     = 3;

  // Request kinds carried in the input tuser.
  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_POLL = 2'd2
  } req_type_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BUSY  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NONE  = 2'd3
  } status_e;

  // One stored task.
  typedef struct packed {
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] interval;
    logic [TIME_W-1:0] deadline;
  } ptq_entry_t;

  // One result item.
  typedef struct packed {
    status_e                 status;
    logic                    fired;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [WORD_W-1:0]       tag;
    logic [TIME_W-1:0]       deadline;
    logic [WORD_W-1:0]       interval;
  } ptq_result_t;

endpackage

@@ hdl/periodic_timer_queue.sv @@
// Periodic timer queue top level: slot store, scan sequencer and result register.
// Holds NUM_SLOTS timer tasks, each a 64-bit microsecond deadline, a 32-bit reload interval
// and a 32-bit tag, in one single-port-read memory with a valid flip-flop per slot. An add or
// a delete item is decided on acceptance and its result registered, ready to load into the
// output register. A poll item walks the memory one slot per cycle through its single read
// port and one shared compare unit; its steps are the reads of every slot, the registered
// read, the close of the scan, the saturating deadline advance or the release of a one-shot
// task, and the load of the result. A poll with nothing due skips the update step. The input
// is ready whenever the sequencer is idle, to which it returns as it loads the result into
// the output register; a finished result waits in the output register while the next item is
// taken in, and a second result waits in the sequencer, with the input held off, until the
// first one leaves. The earliest due deadline wins, and ties go to the lowest slot.
module periodic_timer_queue #(
  parameter int unsigned NUM_SLOTS = ptq_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // From bit 0: slot[3:0], first_deadline[67:4], start_now[68], reload_interval[100:69],
  // task_tag[132:101], current_time[196:133], zero fill[199:197].
  input  logic [ptq_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // From bit 0: req_type[1:0].
  input  logic [ptq_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // From bit 0: fired_slot[3:0], fired_tag[35:4], fired_deadline[99:36],
  // fired_interval[131:100], zero fill[135:132].
  output logic [ptq_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // From bit 0: status[1:0], fired[2].
  output logic [ptq_pkg::M_TUSER_W-1:0]  m_axis_tuser_o
);

  import ptq_pkg::*;

  `include "periodic_timer_queue_defines.svh"

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  // Control state.
  state_e                state_q, state_d;
  logic [NUM_SLOTS-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic                  found_q, found_d;
  logic                  out_vld_q, out_vld_d;

  // Payload state.
  logic [SLOT_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [SLOT_W-1:0]     best_idx_q, best_idx_d;
  ptq_entry_t            best_q, best_d;
  logic [TIME_W-1:0]     now_q, now_d;
  ptq_result_t           res_q, res_d;
  ptq_result_t           out_q, out_d;

  // Task memory.
  ptq_entry_t            slot_mem_q [NUM_SLOTS];
  ptq_entry_t            rd_q;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_wa;
  ptq_entry_t            mem_wd;

  // Input field unpacking.
  logic [1:0]              in_req;
  logic [SLOT_FIELD_W-1:0] in_slot;
  logic [TIME_W-1:0]       in_first;
  logic                    in_start_now;
  logic [WORD_W-1:0]       in_ival;
  logic [WORD_W-1:0]       in_tag;
  logic [TIME_W-1:0]       in_now;

  assign in_req       = s_axis_tuser_i[1:0];
  assign in_slot      = s_axis_tdata_i[3:0];
  assign in_first     = s_axis_tdata_i[67:4];
  assign in_start_now = s_axis_tdata_i[68];
  assign in_ival      = s_axis_tdata_i[100:69];
  assign in_tag       = s_axis_tdata_i[132:101];
  assign in_now       = s_axis_tdata_i[196:133];

  // Slot address range check and index.
  logic [SLOT_W+SLOT_FIELD_W-1:0] in_slot_ext;
  logic [SLOT_W-1:0]              in_idx;
  logic                           in_slot_ok;

  assign in_slot_ext = {{SLOT_W{1'b0}}, in_slot};
  assign in_idx      = in_slot_ext[SLOT_W-1:0];
  assign in_slot_ok  = ({5'b0, in_slot} < 9'(NUM_SLOTS));

  // Shared compare unit: is the slot under test due and earlier than the best so far.
  logic scan_hit;
  assign scan_hit = cmp_vld_q && valid_q[cmp_idx_q] && (rd_q.deadline <= now_q) &&
                    (!found_q || (rd_q.deadline < best_q.deadline));

  // Saturating deadline advance of the chosen task.
  logic [TIME_W:0]                 adv_sum;
  logic [TIME_W-1:0]               adv_deadline;
  logic [SLOT_W+SLOT_FIELD_W-1:0]  best_idx_ext;

  assign adv_sum      = {1'b0, best_q.deadline} + {{(TIME_W-WORD_W+1){1'b0}}, best_q.interval};
  assign adv_deadline = adv_sum[TIME_W] ? {TIME_W{1'b1}} : adv_sum[TIME_W-1:0];
  assign best_idx_ext = {{SLOT_FIELD_W{1'b0}}, best_idx_q};

  // Scan issue condition.
  logic scan_issue;
  assign scan_issue = (cnt_q < CNT_W'(NUM_SLOTS));
  assign rd_addr    = cnt_q[SLOT_W-1:0];

  // Sequencer next-state logic.
  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    found_d    = found_q;
    out_vld_d  = out_vld_q;
    cmp_idx_d  = cmp_idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    now_d      = now_q;
    res_d      = res_q;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_wa     = in_idx;
    mem_wd     = '{tag: in_tag, interval: in_ival,
                   deadline: (in_start_now ? in_now : in_first)};

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_d   = '0;
          state_d = ST_RESULT;
          unique case (in_req)
            REQ_ADD: begin
              if (!in_slot_ok || valid_q[in_idx]) begin
                res_d.status = STAT_BUSY;
              end else begin
                mem_we          = 1'b1;
                valid_d[in_idx] = 1'b1;
                res_d.status    = STAT_OK;
              end
            end
            REQ_DEL: begin
              if (!in_slot_ok || !valid_q[in_idx]) begin
                res_d.status = STAT_EMPTY;
              end else begin
                valid_d[in_idx] = 1'b0;
                res_d.status    = STAT_OK;
              end
            end
            REQ_POLL: begin
              now_d   = in_now;
              cnt_d   = '0;
              found_d = 1'b0;
              state_d = ST_SCAN;
            end
            default: begin
              res_d.status = STAT_NONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; compare the word read in the cycle before.
        if (scan_issue) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr;
          cnt_d     = cnt_q + CNT_W'(1);
        end
        if (scan_hit) begin
          found_d    = 1'b1;
          best_d     = rd_q;
          best_idx_d = cmp_idx_q;
        end
        if (!scan_issue && !cmp_vld_q) begin
          if (found_q) begin
            state_d = ST_UPDATE;
          end else begin
            res_d        = '0;
            res_d.status = STAT_NONE;
            state_d      = ST_RESULT;
          end
        end
      end

      ST_UPDATE: begin
        // Reload a periodic task, release a one-shot task.
        if (best_q.interval != '0) begin
          mem_we = 1'b1;
          mem_wa = best_idx_q;
          mem_wd = '{tag: best_q.tag, interval: best_q.interval, deadline: adv_deadline};
        end else begin
          valid_d[best_idx_q] = 1'b0;
        end
        res_d.status   = STAT_OK;
        res_d.fired    = 1'b1;
        res_d.slot     = best_idx_ext[SLOT_FIELD_W-1:0];
        res_d.tag      = best_q.tag;
        res_d.deadline = best_q.deadline;
        res_d.interval = best_q.interval;
        found_d        = 1'b0;
        state_d        = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    now_q      <= now_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // Task memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= slot_mem_q[rd_addr];
  end

  // Port outputs.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_q.interval, out_q.deadline, out_q.tag, out_q.slot};
  assign m_axis_tuser_o  = {out_q.fired, out_q.status};

  // Checks on the sequencer.
  `PTQ_ASSERT_NEXT(a_poll_starts_scan,
                   s_axis_tvalid_i && s_axis_tready_o && (in_req == REQ_POLL),
                   state_q == ST_SCAN && cnt_q == '0 && !found_q,
                   "poll did not start a fresh scan")
  `PTQ_ASSERT_SAME(a_best_is_due, found_q, best_q.deadline <= now_q,
                   "chosen task is not due")
  `PTQ_ASSERT_NEXT(a_oneshot_freed, state_q == ST_UPDATE && best_q.interval == '0,
                   !valid_q[$past(best_idx_q)], "fired one-shot task still valid")
  `PTQ_ASSERT_SAME(a_fired_ok, m_axis_tvalid_o && m_axis_tuser_o[2],
                   m_axis_tuser_o[1:0] == STAT_OK, "fired result without ok status")

endmodule

@@ sim/tb_periodic_timer_queue.sv @@
// Self-checking testbench for the periodic timer queue: stream driver, result monitor and scoreboard.
module tb_periodic_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import ptq_pkg::*;

  localparam int unsigned SLOTS        = NUM_SLOTS_DEF;
  localparam int unsigned RANDOM_REQS  = 500;
  localparam int unsigned QUIET_TAIL   = 80;
  localparam int unsigned DRAIN_CYCLES = 4 * (SLOTS + 4);
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SHOWN_ERRORS = 40;
  // Request kind that the block answers without acting on it.
  localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;
  localparam logic [63:0] TIME_MAX     = '1;

  // One request item as the host builds it.
  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [63:0] first;
    logic        start_now;
    logic [31:0] period;
    logic [31:0] word;
    logic [63:0] now;
  } timer_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  periodic_timer_queue #(
    .NUM_SLOTS(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  // Host side bookkeeping.
  timer_req_t  request_backlog[$];
  ptq_result_t awaited_answers[$];
  int unsigned total_reqs = 0;
  int unsigned accepted_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Mirror of the slot store as the block should hold it.
  logic        mirror_live[SLOTS];
  logic [63:0] mirror_deadline[SLOTS];
  logic [31:0] mirror_period[SLOTS];
  logic [31:0] mirror_tag[SLOTS];

  // Tallies for the closing summary.
  int unsigned fire_cnt = 0;
  int unsigned oneshot_cnt = 0;
  int unsigned saturate_cnt = 0;
  int unsigned busy_cnt = 0;
  int unsigned empty_cnt = 0;
  int unsigned idle_poll_cnt = 0;

  logic quiet;
  assign quiet = (total_reqs != 0) && (accepted_cnt + QUIET_TAIL >= total_reqs);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= SHOWN_ERRORS)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic queue_req(input logic [1:0] kind, input logic [3:0] slot,
                           input logic [63:0] first, input logic start_now,
                           input logic [31:0] period, input logic [31:0] word,
                           input logic [63:0] now);
    timer_req_t r;
    r.kind      = kind;
    r.slot      = slot;
    r.first     = first;
    r.start_now = start_now;
    r.period    = period;
    r.word      = word;
    r.now       = now;
    request_backlog.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Works out the answer to one request and updates the mirrored slots.
  function automatic ptq_result_t answer_request(input timer_req_t r);
    ptq_result_t res;
    logic        found;
    int unsigned best;
    logic [64:0] sum;
    res        = '0;
    res.status = STAT_NONE;
    found      = 1'b0;
    best       = 0;
    case (r.kind)
      REQ_ADD: begin
        if (r.slot >= SLOTS || mirror_live[r.slot]) begin
          res.status = STAT_BUSY;
          busy_cnt++;
        end else begin
          mirror_live[r.slot]     = 1'b1;
          mirror_deadline[r.slot] = r.start_now ? r.now : r.first;
          mirror_period[r.slot]   = r.period;
          mirror_tag[r.slot]      = r.word;
          res.status              = STAT_OK;
        end
      end
      REQ_DEL: begin
        if (r.slot >= SLOTS || !mirror_live[r.slot]) begin
          res.status = STAT_EMPTY;
          empty_cnt++;
        end else begin
          mirror_live[r.slot] = 1'b0;
          res.status          = STAT_OK;
        end
      end
      REQ_POLL: begin
        // Earliest due deadline wins; a strict compare keeps ties on the lowest slot.
        for (int unsigned i = 0; i < SLOTS; i++) begin
          if (mirror_live[i] && mirror_deadline[i] <= r.now &&
              (!found || mirror_deadline[i] < mirror_deadline[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          idle_poll_cnt++;
        end else begin
          fire_cnt++;
          res.status   = STAT_OK;
          res.fired    = 1'b1;
          res.slot     = best[3:0];
          res.tag      = mirror_tag[best];
          res.deadline = mirror_deadline[best];
          res.interval = mirror_period[best];
          if (mirror_period[best] != '0) begin
            // The advanced deadline saturates instead of wrapping.
            sum = {1'b0, mirror_deadline[best]} + {33'b0, mirror_period[best]};
            if (sum[64]) begin
              mirror_deadline[best] = TIME_MAX;
              saturate_cnt++;
            end else begin
              mirror_deadline[best] = sum[63:0];
            end
          end else begin
            mirror_live[best] = 1'b0;
            oneshot_cnt++;
          end
        end
      end
      default: begin
        res.status = STAT_NONE;
      end
    endcase
    return res;
  endfunction

  // Request driver: takes items from the backlog, with random gaps between them.
  timer_req_t  on_bus;
  int unsigned tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_answers.push_back(answer_request(on_bus));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (request_backlog.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          tx_gap        <= $urandom_range(1, 15) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          on_bus        = request_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= on_bus.kind;
          s_axis_tdata  <= {3'b000, on_bus.now, on_bus.word, on_bus.period,
                            on_bus.start_now, on_bus.first, on_bus.slot};
        end
      end
    end
  end

  // One long receiver hold-off, so that the block backs up and stalls its input.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result ready: random stall bursts, none in the closing stretch.
  int unsigned rx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
      rx_gap        <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap        <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rx_gap        <= $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor: each accepted item is checked against the oldest awaited answer.
  always @(posedge clk_i) begin
    ptq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("result with nothing outstanding", m_axis_tdata[99:36],
                        64'h0);
      end else begin
        want = awaited_answers.pop_front();
        if (m_axis_tuser[1:0] !== want.status)
          report_mismatch("status", m_axis_tuser[1:0], want.status);
        if (m_axis_tuser[2] !== want.fired)
          report_mismatch("fired", m_axis_tuser[2], want.fired);
        if (m_axis_tdata[3:0] !== want.slot)
          report_mismatch("fired_slot", m_axis_tdata[3:0], want.slot);
        if (m_axis_tdata[35:4] !== want.tag)
          report_mismatch("fired_tag", m_axis_tdata[35:4], want.tag);
        if (m_axis_tdata[99:36] !== want.deadline)
          report_mismatch("fired_deadline", m_axis_tdata[99:36], want.deadline);
        if (m_axis_tdata[131:100] !== want.interval)
          report_mismatch("fired_interval", m_axis_tdata[131:100], want.interval);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d answers outstanding", cycles,
               awaited_answers.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : main_flow
    logic [63:0] gen_now;
    logic [63:0] first;
    logic [31:0] period;
    logic        start_now;
    int unsigned counted;
    int unsigned pick;

    for (int unsigned i = 0; i < SLOTS; i++) begin
      mirror_live[i]     = 1'b0;
      mirror_deadline[i] = '0;
      mirror_period[i]   = '0;
      mirror_tag[i]      = '0;
    end

    // Directed part: empty queue, busy and empty slots, ties, one-shot release,
    // saturation at the top of the time range, zero deadline, unknown kind.
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd0);
    queue_req(REQ_DEL, 4'd3, TIME_MAX, 1'b1, '1, '1, TIME_MAX);
    queue_req(REQ_ADD, 4'd0, 64'd100, 1'b0, 32'd50, 32'hAAAA_5555, 64'd0);
    queue_req(REQ_ADD, 4'd0, 64'd7, 1'b0, 32'd1, 32'h1234_5678, 64'd0);
    queue_req(REQ_ADD, 4'd15, TIME_MAX, 1'b1, 32'd0, 32'hFFFF_FFFF, 64'd100);
    queue_req(REQ_ADD, 4'd7, 64'd100, 1'b0, 32'd0, 32'h0000_0001, 64'd0);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd99);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd100);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd100);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd100);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd100);
    queue_req(REQ_ADD, 4'd1, TIME_MAX - 1, 1'b0, 32'hFFFF_FFFF, 32'h0, 64'd0);
    queue_req(REQ_DEL, 4'd0, '0, 1'b0, '0, '0, '0);
    queue_req(REQ_DEL, 4'd0, '0, 1'b0, '0, '0, '0);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, TIME_MAX);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, TIME_MAX);
    queue_req(REQ_DEL, 4'd1, '0, 1'b0, '0, '0, '0);
    queue_req(REQ_ADD, 4'd2, 64'd0, 1'b0, 32'd0, 32'h5A5A_A5A5, 64'd0);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd0);
    queue_req(REQ_UNKNOWN, 4'hF, TIME_MAX, 1'b1, '1, '1, TIME_MAX);
    queue_req(REQ_ADD, 4'd4, 64'd5, 1'b0, 32'd1, 32'hC0DE_0004, 64'd0);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd4);
    queue_req(REQ_POLL, 4'd0, '0, 1'b0, '0, '0, 64'd6);
    queue_req(REQ_DEL, 4'd4, '0, 1'b0, '0, '0, '0);

    // Random part: time moves forward and most deadlines land near it, so that
    // polls keep firing; a few items carry values from the whole field range.
    gen_now = 64'd1000;
    counted = 0;
    while (counted < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_req(REQ_UNKNOWN, 4'($urandom), rand64(), 1'($urandom), $urandom, $urandom,
                  rand64());
      end else if (pick < 40) begin
        first = ($urandom_range(0, 15) == 0) ? rand64()
                                             : gen_now + 64'($urandom_range(0, 4000));
        case ($urandom_range(0, 11))
          0, 1, 2, 3: period = '0;
          4:          period = $urandom;
          default:    period = $urandom_range(1, 3000);
        endcase
        start_now = ($urandom_range(0, 3) == 0);
        queue_req(REQ_ADD, 4'($urandom), first, start_now, period, $urandom,
                  (start_now || $urandom_range(0, 3) != 0) ? gen_now : rand64());
        counted++;
      end else if (pick < 60) begin
        queue_req(REQ_DEL, 4'($urandom), rand64(), 1'($urandom), $urandom, $urandom,
                  rand64());
        counted++;
      end else begin
        gen_now = gen_now + 64'($urandom_range(0, 1500));
        queue_req(REQ_POLL, 4'($urandom), rand64(), 1'($urandom), $urandom, $urandom,
                  ($urandom_range(0, 19) == 0) ? rand64() : gen_now);
        counted++;
      end
    end
    total_reqs = request_backlog.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every answer, then give the block time to show any stray result.
    while (accepted_cnt != total_reqs || awaited_answers.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d tasks fired (%0d one-shot releases, %0d saturated).",
             total_reqs, fire_cnt, oneshot_cnt, saturate_cnt);
    $display("%0d busy adds, %0d empty deletes, %0d polls with nothing due, %0d errors.",
             busy_cnt, empty_cnt, idle_poll_cnt, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
